// ===== hw/rtl/crcfr_pkg.sv =====
// shared types, constants and crc function for the crc16 frame receiver
package crcfr_pkg;

	localparam int RING_DEPTH_DEF  = 256;
	localparam int PAYLOAD_MAX_DEF = 16;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [7:0] START_BYTE_RST     = 8'h00;
	localparam logic [4:0] PAYLOAD_LENGTH_RST = 5'd8;

	typedef enum logic [0:0] {
		CFG_START_BYTE     = 1'b0,
		CFG_PAYLOAD_LENGTH = 1'b1
	} cfg_idx_t;

	typedef enum logic [0:0] {
		OPC_PUSH = 1'b0,
		OPC_READ = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		STS_PUSH_OK   = 2'd0,
		STS_PUSH_FULL = 2'd1,
		STS_PAYLOAD   = 2'd2,
		STS_NO_FRAME  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_CHECK,
		ST_CRC_RD,
		ST_CRC_ACC,
		ST_RXLO_RD,
		ST_RXLO,
		ST_RXHI_RD,
		ST_RXHI,
		ST_EMIT_RD,
		ST_EMIT,
		ST_CONSUME1,
		ST_CONSUME2
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_PUSH,
		OP_NOFRAME,
		OP_READ_START,
		OP_SCAN_DROP,
		OP_CRC_START,
		OP_CRC_ACC,
		OP_RX_LO,
		OP_MISMATCH,
		OP_EMIT_START,
		OP_EMIT_BYTE,
		OP_CONSUME
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic too_short;   // held bytes below one whole frame
		logic held_zero;
		logic start_match;
		logic cnt_last;
		logic crc_ok;
	} dp_stat_t;

	// crc-16/ccitt-false, msb first, one byte
	function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
		input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int b = 0; b < 8; b++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/crcfr_ctrl.sv =====
// controller state machine for the crc16 frame receiver
module crcfr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                opcode,
	input  crcfr_pkg::dp_stat_t stat,
	output crcfr_pkg::dp_cmd_t  cmd,
	output logic                busy
);

	crcfr_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crcfr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.op  = crcfr_pkg::OP_NONE;
		busy    = 1'b1;
		unique case (state_q)
			crcfr_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (opcode == crcfr_pkg::OPC_PUSH) begin
						cmd.op = crcfr_pkg::OP_PUSH;
					end else if (stat.too_short) begin
						cmd.op = crcfr_pkg::OP_NOFRAME;
					end else begin
						cmd.op  = crcfr_pkg::OP_READ_START;
						state_d = crcfr_pkg::ST_SCAN_RD;
					end
				end
			end
			crcfr_pkg::ST_SCAN_RD: begin
				// nothing left to scan: pointers have met, store is empty
				if (stat.held_zero) begin
					cmd.op  = crcfr_pkg::OP_NOFRAME;
					state_d = crcfr_pkg::ST_IDLE;
				end else begin
					state_d = crcfr_pkg::ST_SCAN_CMP;
				end
			end
			crcfr_pkg::ST_SCAN_CMP: begin
				if (stat.start_match) begin
					state_d = crcfr_pkg::ST_CHECK;
				end else begin
					cmd.op  = crcfr_pkg::OP_SCAN_DROP;
					state_d = crcfr_pkg::ST_SCAN_RD;
				end
			end
			crcfr_pkg::ST_CHECK: begin
				if (stat.too_short) begin
					cmd.op  = crcfr_pkg::OP_NOFRAME;
					state_d = crcfr_pkg::ST_IDLE;
				end else begin
					cmd.op  = crcfr_pkg::OP_CRC_START;
					state_d = crcfr_pkg::ST_CRC_RD;
				end
			end
			crcfr_pkg::ST_CRC_RD: begin
				state_d = crcfr_pkg::ST_CRC_ACC;
			end
			crcfr_pkg::ST_CRC_ACC: begin
				cmd.op  = crcfr_pkg::OP_CRC_ACC;
				state_d = stat.cnt_last ? crcfr_pkg::ST_RXLO_RD : crcfr_pkg::ST_CRC_RD;
			end
			crcfr_pkg::ST_RXLO_RD: begin
				state_d = crcfr_pkg::ST_RXLO;
			end
			crcfr_pkg::ST_RXLO: begin
				cmd.op  = crcfr_pkg::OP_RX_LO;
				state_d = crcfr_pkg::ST_RXHI_RD;
			end
			crcfr_pkg::ST_RXHI_RD: begin
				state_d = crcfr_pkg::ST_RXHI;
			end
			crcfr_pkg::ST_RXHI: begin
				if (stat.crc_ok) begin
					cmd.op  = crcfr_pkg::OP_EMIT_START;
					state_d = crcfr_pkg::ST_EMIT_RD;
				end else begin
					cmd.op  = crcfr_pkg::OP_MISMATCH;
					state_d = crcfr_pkg::ST_IDLE;
				end
			end
			crcfr_pkg::ST_EMIT_RD: begin
				state_d = crcfr_pkg::ST_EMIT;
			end
			crcfr_pkg::ST_EMIT: begin
				cmd.op  = crcfr_pkg::OP_EMIT_BYTE;
				state_d = stat.cnt_last ? crcfr_pkg::ST_CONSUME1 : crcfr_pkg::ST_EMIT_RD;
			end
			crcfr_pkg::ST_CONSUME1: begin
				cmd.op  = crcfr_pkg::OP_CONSUME;
				state_d = crcfr_pkg::ST_CONSUME2;
			end
			crcfr_pkg::ST_CONSUME2: begin
				cmd.op  = crcfr_pkg::OP_CONSUME;
				state_d = crcfr_pkg::ST_IDLE;
			end
			default: begin
				state_d = crcfr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/crcfr_dp.sv =====
// datapath: receive ring, pointers, crc unit, config and result registers
module crcfr_dp #(
	parameter int RING_DEPTH  = crcfr_pkg::RING_DEPTH_DEF,
	parameter int PAYLOAD_MAX = crcfr_pkg::PAYLOAD_MAX_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  crcfr_pkg::dp_cmd_t  cmd,
	output crcfr_pkg::dp_stat_t stat,
	input  logic [7:0]          data_byte,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_data,
	output logic                strobe,
	output logic [1:0]          status,
	output logic [7:0]          payload_byte,
	output logic                last
);

	localparam int PW = $clog2(RING_DEPTH);
	localparam int HW = $clog2(RING_DEPTH + 1);
	localparam int LW = $clog2(PAYLOAD_MAX + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(RING_DEPTH - 1);
	localparam logic [HW-1:0] HELD_FULL = HW'(RING_DEPTH);

	logic [7:0]    mem [RING_DEPTH];
	logic [7:0]    rd_data_q;
	logic [PW-1:0] rp_q, wp_q, ptr_q;
	logic [HW-1:0] held_q;
	logic [7:0]    start_byte_q;
	logic [4:0]    plen_q;
	logic [LW-1:0] cnt_q;
	logic [15:0]   crc_q;
	logic [7:0]    rx_lo_q;
	logic          strobe_q, last_q;
	logic [1:0]    status_q;
	logic [7:0]    payload_q;

	logic [LW-1:0] len_c;
	logic          full_c;
	logic [PW-1:0] rp_inc, ptr_inc, wp_inc;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PW'(1);
	endfunction

	// payload length saturated to 1..PAYLOAD_MAX
	always_comb begin
		if (plen_q == 5'd0) begin
			len_c = LW'(1);
		end else if (32'(plen_q) > 32'(PAYLOAD_MAX)) begin
			len_c = LW'(PAYLOAD_MAX);
		end else begin
			len_c = LW'(plen_q);
		end
	end

	assign full_c  = (held_q == HELD_FULL);
	assign rp_inc  = ptr_next(rp_q);
	assign ptr_inc = ptr_next(ptr_q);
	assign wp_inc  = ptr_next(wp_q);

	assign stat.too_short   = (32'(held_q) < (32'(len_c) + 32'd3));
	assign stat.held_zero   = (held_q == '0);
	assign stat.start_match = (rd_data_q == start_byte_q);
	assign stat.cnt_last    = ((LW + 1)'(cnt_q) + (LW + 1)'(1) == (LW + 1)'(len_c));
	assign stat.crc_ok      = ({rd_data_q, rx_lo_q} == crc_q);

	// ring memory, registered read at the working pointer
	always_ff @(posedge clk) begin
		if (cmd.op == crcfr_pkg::OP_PUSH && !full_c) begin
			mem[wp_q] <= data_byte;
		end
		rd_data_q <= mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= crcfr_pkg::START_BYTE_RST;
			plen_q       <= crcfr_pkg::PAYLOAD_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				crcfr_pkg::CFG_START_BYTE:     start_byte_q <= cfg_data;
				crcfr_pkg::CFG_PAYLOAD_LENGTH: plen_q       <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q     <= '0;
			wp_q     <= '0;
			held_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (cmd.op)
				crcfr_pkg::OP_PUSH: begin
					strobe_q <= 1'b1;
					if (!full_c) begin
						wp_q   <= wp_inc;
						held_q <= held_q + HW'(1);
					end
				end
				crcfr_pkg::OP_NOFRAME: begin
					strobe_q <= 1'b1;
				end
				crcfr_pkg::OP_MISMATCH: begin
					strobe_q <= 1'b1;
					rp_q     <= rp_inc;
					held_q   <= held_q - HW'(1);
				end
				crcfr_pkg::OP_SCAN_DROP, crcfr_pkg::OP_EMIT_START,
				crcfr_pkg::OP_CONSUME: begin
					rp_q   <= rp_inc;
					held_q <= held_q - HW'(1);
				end
				crcfr_pkg::OP_EMIT_BYTE: begin
					strobe_q <= 1'b1;
					rp_q     <= rp_inc;
					held_q   <= held_q - HW'(1);
				end
				default: ;
			endcase
		end
	end

	// working registers and result payload
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			crcfr_pkg::OP_PUSH: begin
				status_q  <= full_c ? crcfr_pkg::STS_PUSH_FULL : crcfr_pkg::STS_PUSH_OK;
				payload_q <= 8'h00;
				last_q    <= 1'b1;
			end
			crcfr_pkg::OP_NOFRAME, crcfr_pkg::OP_MISMATCH: begin
				status_q  <= crcfr_pkg::STS_NO_FRAME;
				payload_q <= 8'h00;
				last_q    <= 1'b1;
			end
			crcfr_pkg::OP_READ_START: begin
				ptr_q <= rp_q;
			end
			crcfr_pkg::OP_SCAN_DROP: begin
				ptr_q <= rp_inc;
			end
			crcfr_pkg::OP_CRC_START: begin
				ptr_q <= rp_inc;
				crc_q <= crcfr_pkg::CRC_INIT;
				cnt_q <= '0;
			end
			crcfr_pkg::OP_CRC_ACC: begin
				crc_q <= crcfr_pkg::crc16_update(crc_q, rd_data_q);
				ptr_q <= ptr_inc;
				cnt_q <= cnt_q + LW'(1);
			end
			crcfr_pkg::OP_RX_LO: begin
				rx_lo_q <= rd_data_q;
				ptr_q   <= ptr_inc;
			end
			crcfr_pkg::OP_EMIT_START: begin
				// start byte is dropped here, first payload byte is next
				ptr_q <= rp_inc;
				cnt_q <= '0;
			end
			crcfr_pkg::OP_EMIT_BYTE: begin
				status_q  <= crcfr_pkg::STS_PAYLOAD;
				payload_q <= rd_data_q;
				last_q    <= stat.cnt_last;
				ptr_q     <= ptr_inc;
				cnt_q     <= cnt_q + LW'(1);
			end
			default: ;
		endcase
	end

	assign strobe       = strobe_q;
	assign status       = status_q;
	assign payload_byte = payload_q;
	assign last         = last_q;

endmodule

// ===== hw/rtl/crc16_frame_receiver_top.sv =====
// top level of the crc16 frame receiver: controller plus datapath
// a push leaves the controller idle; its result beat appears on the next cycle, and
// start is taken again at once, so pushes run at one per cycle.
// a read drops bytes up to the start byte, checks the length, runs the crc over the payload,
// checks the two crc bytes, and on a match delivers the payload and drops the crc bytes,
// all via the single registered read port of the ring; short reads answer the next cycle.
// arst_n empties the ring, clears the read and write pointers and restores the config defaults.
module crc16_frame_receiver_top #(
	parameter int RING_DEPTH  = crcfr_pkg::RING_DEPTH_DEF,
	parameter int PAYLOAD_MAX = crcfr_pkg::PAYLOAD_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       opcode,
	input  logic [7:0] data_byte,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	output logic       strobe,
	output logic [1:0] status,
	output logic [7:0] payload_byte,
	output logic       last
);

	crcfr_pkg::dp_cmd_t  cmd;
	crcfr_pkg::dp_stat_t stat;
	logic                busy_c;

	crcfr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy_c)
	);

	crcfr_dp #(
		.RING_DEPTH  (RING_DEPTH),
		.PAYLOAD_MAX (PAYLOAD_MAX)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.data_byte    (data_byte),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.strobe       (strobe),
		.status       (status),
		.payload_byte (payload_byte),
		.last         (last)
	);

	assign busy      = busy_c;
	// no config beat in the cycle an item is taken
	assign cfg_ready = !busy_c && !start;

endmodule
